### sv/cylinder_mesh_tessellator_macros.svh
// ----------------------------------------------------------------------------
// cylinder_mesh_tessellator assertion macros
// Shared concurrent assertion forms for the tessellator checkers.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_MESH_TESSELLATOR_MACROS_SVH
`define CYLINDER_MESH_TESSELLATOR_MACROS_SVH

// Next-cycle implication, ignored while reset is high
`define CMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also holds across reset
`define CMT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### sv/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types, constants and tables of the cylinder tessellator.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int MAX_SLICES   = 256;
  localparam int MAX_STACKS   = 31;
  localparam int CORDIC_STEPS = 16;

  localparam int SLICE_W = 9;
  localparam int STACK_W = 5;
  localparam int IDX_W   = 14;
  localparam int ADDR_W  = 2;

  // Register indexes of the configuration port
  localparam logic [ADDR_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [ADDR_W-1:0] REG_SLICES = 2'd1;
  localparam logic [ADDR_W-1:0] REG_STACKS = 2'd2;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] HALF_Q16    = 32'sd32768;

  typedef logic signed [31:0] coord_t;

  // One slice's work, passed from front to back
  typedef struct packed {
    coord_t             x2;
    coord_t             z2;
    coord_t             x3;
    coord_t             z3;
    logic [IDX_W-1:0]   base;
    logic [STACK_W-1:0] stacks;
    logic [16:0]        lvl_q;
    logic [STACK_W-1:0] lvl_r;
  } slice_job_t;

  // Arctangent of 2^-i as a fraction of a turn
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### sv/cmt_front.sv
// ----------------------------------------------------------------------------
// cmt_front
// Accepts a slice index, finds the two rim points (divide, CORDIC, scale)
// and the stack level stride, then hands one job to the queue.
// ----------------------------------------------------------------------------
module cmt_front import cmt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         slice_index,
  output logic               full,
  input  logic [15:0]        radius,
  input  logic [SLICE_W-1:0] slice_count,
  input  logic [STACK_W-1:0] stack_count,
  output logic               job_valid,
  output slice_job_t         job,
  input  logic               job_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_CORD  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } rot_t;

  typedef struct packed {
    coord_t c;
    coord_t s;
  } cs_t;

  logic [2:0]         state;
  logic [4:0]         cnt;
  logic [SLICE_W-1:0] slices;
  logic [STACK_W-1:0] stacks;
  logic [31:0]        quo_a, quo_b;
  logic [SLICE_W-1:0] rem_a, rem_b;
  logic [16:0]        quo_s;
  logic [STACK_W-1:0] rem_s;
  logic [1:0]         quad_a, quad_b;
  rot_t               rot_a, rot_b;
  coord_t             x2, z2, x3, z3;
  logic [IDX_W-1:0]   base;

  logic [SLICE_W-1:0] slices_eff;
  logic [STACK_W-1:0] stacks_eff;
  logic [SLICE_W-1:0] kb;
  logic [SLICE_W:0]   ra2, rb2;
  logic [SLICE_W:0]   ra_sub, rb_sub;
  logic               ra_ge, rb_ge;
  logic [STACK_W:0]   rs2, rs_sub;
  logic               rs_ge;
  logic [32:0]        sum_a, sum_b;
  logic [33:0]        z34_a, z34_b;
  rot_t               step_a, step_b;
  cs_t                cs_a, cs_b;
  coord_t             mul_op;
  logic signed [48:0] prod;
  logic signed [48:0] rounded;
  logic [14:0]        base_full;

  function automatic rot_t cordic_step(input rot_t r, input logic [4:0] i);
    rot_t   o;
    coord_t dx, dy;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (!r.z[31]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - $signed(atan_turns(i));
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + $signed(atan_turns(i));
    end
    return o;
  endfunction

  function automatic cs_t quad_apply(input logic [1:0] q, input rot_t r);
    cs_t o;
    case (q)
      2'd0:    begin o.c = r.x;  o.s = r.y;  end
      2'd1:    begin o.c = -r.y; o.s = r.x;  end
      2'd2:    begin o.c = -r.x; o.s = -r.y; end
      default: begin o.c = r.y;  o.s = -r.x; end
    endcase
    return o;
  endfunction

  // Clamp configuration to the supported range
  always_comb begin
    if (slice_count < SLICE_W'(3)) slices_eff = SLICE_W'(3);
    else if (slice_count > SLICE_W'(MAX_SLICES)) slices_eff = SLICE_W'(MAX_SLICES);
    else slices_eff = slice_count;
    if (stack_count == '0) stacks_eff = STACK_W'(1);
    else if (stack_count > STACK_W'(MAX_STACKS)) stacks_eff = STACK_W'(MAX_STACKS);
    else stacks_eff = stack_count;
  end

  assign kb        = {1'b0, slice_index} + SLICE_W'(1);
  assign base_full = 15'(slice_index * ({1'b0, stacks_eff, 1'b0} + 7'd2));

  // One restoring quotient bit per divider
  assign ra2    = {rem_a, 1'b0};
  assign rb2    = {rem_b, 1'b0};
  assign ra_ge  = ra2 >= {1'b0, slices};
  assign rb_ge  = rb2 >= {1'b0, slices};
  assign ra_sub = ra2 - {1'b0, slices};
  assign rb_sub = rb2 - {1'b0, slices};
  assign rs2    = {rem_s, (cnt == 5'd15)};
  assign rs_ge  = rs2 >= {1'b0, stacks};
  assign rs_sub = rs2 - {1'b0, stacks};

  // Fold phase to an octant-centered residual plus quadrant
  assign sum_a = {1'b0, quo_a} + 33'h020000000;
  assign sum_b = {1'b0, quo_b} + 33'h020000000;
  assign z34_a = {2'b00, quo_a} - {1'b0, sum_a[32:30], 30'b0};
  assign z34_b = {2'b00, quo_b} - {1'b0, sum_b[32:30], 30'b0};

  assign step_a = cordic_step(rot_a, cnt);
  assign step_b = cordic_step(rot_b, cnt);
  assign cs_a   = quad_apply(quad_a, rot_a);
  assign cs_b   = quad_apply(quad_b, rot_b);

  // Share one multiplier over the four rim coordinates
  always_comb begin
    case (cnt[1:0])
      2'd0:    mul_op = cs_a.c;
      2'd1:    mul_op = cs_a.s;
      2'd2:    mul_op = cs_b.c;
      default: mul_op = cs_b.s;
    endcase
  end

  assign prod    = $signed({1'b0, radius}) * mul_op;
  assign rounded = (prod + 49'sd2097152) >>> 22;

  assign full      = (state != S_IDLE);
  assign job_valid = (state == S_PUSH);
  assign job.x2     = x2;
  assign job.z2     = z2;
  assign job.x3     = x3;
  assign job.z3     = z3;
  assign job.base   = base;
  assign job.stacks = stacks;
  assign job.lvl_q  = quo_s;
  assign job.lvl_r  = rem_s;

  // Sequence one slice through divide, rotate and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push && ({1'b0, slice_index} < slices_eff)) begin
            slices <= slices_eff;
            stacks <= stacks_eff;
            rem_a  <= {1'b0, slice_index};
            rem_b  <= (kb == slices_eff) ? '0 : kb;
            rem_s  <= '0;
            quo_a  <= '0;
            quo_b  <= '0;
            quo_s  <= '0;
            base   <= base_full[IDX_W-1:0];
            cnt    <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem_a <= ra_ge ? ra_sub[SLICE_W-1:0] : ra2[SLICE_W-1:0];
          rem_b <= rb_ge ? rb_sub[SLICE_W-1:0] : rb2[SLICE_W-1:0];
          rem_s <= rs_ge ? rs_sub[STACK_W-1:0] : rs2[STACK_W-1:0];
          quo_a <= {quo_a[30:0], ra_ge};
          quo_b <= {quo_b[30:0], rb_ge};
          quo_s <= {quo_s[15:0], rs_ge};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_PREP;
        end
        S_PREP: begin
          quad_a  <= sum_a[31:30];
          quad_b  <= sum_b[31:30];
          rot_a.x <= CORDIC_GAIN;
          rot_a.y <= '0;
          rot_a.z <= z34_a[31:0];
          rot_b.x <= CORDIC_GAIN;
          rot_b.y <= '0;
          rot_b.z <= z34_b[31:0];
          cnt     <= '0;
          state   <= S_CORD;
        end
        S_CORD: begin
          rot_a <= step_a;
          rot_b <= step_b;
          if (cnt == 5'(CORDIC_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_SCALE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SCALE: begin
          case (cnt[1:0])
            2'd0:    x2 <= rounded[31:0];
            2'd1:    z2 <= rounded[31:0];
            2'd2:    x3 <= rounded[31:0];
            default: z3 <= rounded[31:0];
          endcase
          cnt <= cnt + 5'd1;
          if (cnt[1:0] == 2'd3) state <= S_PUSH;
        end
        S_PUSH: begin
          if (job_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/cmt_queue.sv
// ----------------------------------------------------------------------------
// cmt_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cmt_queue import cmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  slice_job_t in_job,
  output logic       in_ready,
  output logic       out_valid,
  output slice_job_t out_job,
  input  logic       out_ready
);

  slice_job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = slots[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  // Store payload
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= in_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

### sv/cmt_back.sv
// ----------------------------------------------------------------------------
// cmt_back
// Walks one slice job and emits its triangles into the result register, one
// per cycle while the receiver pops them.
// ----------------------------------------------------------------------------
module cmt_back import cmt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  slice_job_t       job,
  output logic             job_ready,
  output logic             empty,
  input  logic             pop,
  output coord_t           ax,
  output coord_t           ay,
  output coord_t           az,
  output coord_t           bx,
  output coord_t           by_coord,
  output coord_t           bz,
  output coord_t           cx,
  output coord_t           cy,
  output coord_t           cz,
  output logic [IDX_W-1:0] triangle_index,
  output logic             last_of_slice
);

  localparam logic [1:0] ST_TOP   = 2'd0;
  localparam logic [1:0] ST_SIDE1 = 2'd1;
  localparam logic [1:0] ST_SIDE2 = 2'd2;
  localparam logic [1:0] ST_BOT   = 2'd3;

  typedef struct packed {
    logic [16:0]        q;
    logic [STACK_W-1:0] r;
  } lvl_t;

  logic               busy;
  logic [1:0]         stage;
  logic [STACK_W-1:0] k;
  slice_job_t         cur;
  logic [16:0]        qa;
  lvl_t               nxt;
  logic [IDX_W-1:0]   tri_idx;
  logic               out_valid;
  logic               advance;
  lvl_t               first_lvl, step_lvl;
  coord_t             yt, yb;

  // Next stack level from running quotient and remainder
  function automatic lvl_t lvl_step(input lvl_t a, input logic [16:0] dq,
                                    input logic [STACK_W-1:0] dr,
                                    input logic [STACK_W-1:0] s);
    lvl_t             o;
    logic [STACK_W:0] sum;
    logic [STACK_W:0] sub;
    sum = {1'b0, a.r} + {1'b0, dr};
    sub = sum - {1'b0, s};
    if (sum >= {1'b0, s}) begin
      o.r = sub[STACK_W-1:0];
      o.q = a.q + dq + 17'd1;
    end else begin
      o.r = sum[STACK_W-1:0];
      o.q = a.q + dq;
    end
    return o;
  endfunction

  assign first_lvl = lvl_step('{q: 17'd0, r: job.stacks >> 1}, job.lvl_q, job.lvl_r,
                              job.stacks);
  assign step_lvl  = lvl_step(nxt, cur.lvl_q, cur.lvl_r, cur.stacks);
  assign yt        = HALF_Q16 - $signed({15'b0, qa});
  assign yb        = HALF_Q16 - $signed({15'b0, nxt.q});

  assign empty     = !out_valid;
  assign job_ready = !busy;
  assign advance   = busy && (!out_valid || pop);

  // Load a job and step through its triangles
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      if (job_valid) begin
        busy    <= 1'b1;
        cur     <= job;
        stage   <= ST_TOP;
        k       <= '0;
        qa      <= '0;
        nxt     <= first_lvl;
        tri_idx <= job.base;
      end
    end else if (advance) begin
      tri_idx <= tri_idx + IDX_W'(1);
      unique case (stage)
        ST_TOP:   stage <= ST_SIDE1;
        ST_SIDE1: stage <= ST_SIDE2;
        ST_SIDE2: begin
          k     <= k + STACK_W'(1);
          qa    <= nxt.q;
          nxt   <= step_lvl;
          stage <= ((k + STACK_W'(1)) == cur.stacks) ? ST_BOT : ST_SIDE1;
        end
        ST_BOT:   busy <= 1'b0;
        default:  busy <= 1'b0;
      endcase
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Fill the result register
  always_ff @(posedge clk) begin
    if (advance) begin
      triangle_index <= tri_idx;
      last_of_slice  <= (stage == ST_BOT);
      case (stage)
        ST_TOP: begin
          ax <= '0;      ay <= HALF_Q16;       az <= '0;
          bx <= cur.x2;  by_coord <= HALF_Q16; bz <= cur.z2;
          cx <= cur.x3;  cy <= HALF_Q16;       cz <= cur.z3;
        end
        ST_SIDE1: begin
          ax <= cur.x2;  ay <= yt;             az <= cur.z2;
          bx <= cur.x2;  by_coord <= yb;       bz <= cur.z2;
          cx <= cur.x3;  cy <= yb;             cz <= cur.z3;
        end
        ST_SIDE2: begin
          ax <= cur.x3;  ay <= yb;             az <= cur.z3;
          bx <= cur.x3;  by_coord <= yt;       bz <= cur.z3;
          cx <= cur.x2;  cy <= yt;             cz <= cur.z2;
        end
        default: begin
          ax <= '0;      ay <= -HALF_Q16;       az <= '0;
          bx <= cur.x3;  by_coord <= -HALF_Q16; bz <= cur.z3;
          cx <= cur.x2;  cy <= -HALF_Q16;       cz <= cur.z2;
        end
      endcase
    end
  end

endmodule

### sv/cylinder_mesh_tessellator.sv
// ----------------------------------------------------------------------------
// cylinder_mesh_tessellator
// Emits the triangles of one slice of a unit-height cylinder per slice index.
// ----------------------------------------------------------------------------
// Input queue: drive slice_index with push while full is low. An index not
// below the clamped slice count is taken and dropped with no result.
// Result queue: while empty is low the oldest triangle is on the ports; pop
// takes it. Each slice yields 2*stacks+2 triangles, the last one flagged by
// last_of_slice.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 radius,
// 1 slice count, 2 stack count); the user must write only while the block is
// idle, which the block itself does not enforce.
// A slice's job passes 32 divide steps for the rim phases, 16 CORDIC steps and
// the shared-multiplier scale of the four rim coordinates before it reaches
// the queue. The front takes no new index until it has handed its job to the
// queue; the back emits one triangle per cycle while the receiver pops, with a
// load between slices, through a two-job queue.
// A stalled receiver holds the result register; the back and then the queue
// fill, and full stays high once the front cannot hand off. Reset empties
// both sides and restores radius 1.0, 16 slices and 1 stack.
// ----------------------------------------------------------------------------
module cylinder_mesh_tessellator import cmt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         slice_index,
  output logic               empty,
  input  logic               pop,
  output coord_t             ax,
  output coord_t             ay,
  output coord_t             az,
  output coord_t             bx,
  output coord_t             by_coord,
  output coord_t             bz,
  output coord_t             cx,
  output coord_t             cy,
  output coord_t             cz,
  output logic [IDX_W-1:0]   triangle_index,
  output logic               last_of_slice,
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0]        radius;
  logic [SLICE_W-1:0] slice_count;
  logic [STACK_W-1:0] stack_count;
  logic               f_valid, f_ready, b_valid, b_ready;
  slice_job_t         f_job, b_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 16'd256;
      slice_count <= SLICE_W'(16);
      stack_count <= STACK_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS: radius      <= cfg_wdata;
        REG_SLICES: slice_count <= cfg_wdata[SLICE_W-1:0];
        REG_STACKS: stack_count <= cfg_wdata[STACK_W-1:0];
        default:    ;
      endcase
    end
  end

  cmt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .slice_index (slice_index),
    .full        (full),
    .radius      (radius),
    .slice_count (slice_count),
    .stack_count (stack_count),
    .job_valid   (f_valid),
    .job         (f_job),
    .job_ready   (f_ready)
  );

  cmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_job    (f_job),
    .in_ready  (f_ready),
    .out_valid (b_valid),
    .out_job   (b_job),
    .out_ready (b_ready)
  );

  cmt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (b_valid),
    .job            (b_job),
    .job_ready      (b_ready),
    .empty          (empty),
    .pop            (pop),
    .ax             (ax),
    .ay             (ay),
    .az             (az),
    .bx             (bx),
    .by_coord       (by_coord),
    .bz             (bz),
    .cx             (cx),
    .cy             (cy),
    .cz             (cz),
    .triangle_index (triangle_index),
    .last_of_slice  (last_of_slice)
  );

endmodule

### sv/cmt_checker.sv
// ----------------------------------------------------------------------------
// cmt_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`include "cylinder_mesh_tessellator_macros.svh"

module cmt_checker import cmt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [IDX_W-1:0] triangle_index,
  input logic             last_of_slice
);

  // Reset drains both sides
  `CMT_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, empty)
  `CMT_ASSERT_NEXT_ALWAYS(a_rst_ready, clk, rst, !full)

  // Within a slice the next triangle follows without a gap
  `CMT_ASSERT_NEXT(a_slice_no_gap, clk, rst, !empty && pop && !last_of_slice, !empty)

  // Triangle indexes count up within a slice
  `CMT_ASSERT_NEXT(a_slice_index_step, clk, rst, !empty && pop && !last_of_slice,
    triangle_index == IDX_W'($past(triangle_index) + IDX_W'(1)))

endmodule

bind cylinder_mesh_tessellator cmt_checker u_cmt_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .triangle_index (triangle_index),
  .last_of_slice  (last_of_slice)
);
